### rtl/drf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types, widths and constants of the deadband report filter.
// ----------------------------------------------------------------------------
package drf_pkg;

  localparam int FLAG_W       = 7;
  localparam int SENSOR_COUNT = 7;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 22;
  localparam int IN_DATA_W    = 96;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_USER_W   = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEARTBEAT = 3'd0,
    CFG_PAN_DB    = 3'd1,
    CFG_TILT_DB   = 3'd2,
    CFG_AMB_DB    = 3'd3,
    CFG_OBJ_DB    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    REASON_NONE      = 4'd0,
    REASON_FORCE     = 4'd1,
    REASON_HEARTBEAT = 4'd2,
    REASON_PUMP      = 4'd3,
    REASON_TILT_FIRE = 4'd4,
    REASON_FLAGS     = 4'd5,
    REASON_PAN       = 4'd6,
    REASON_TILT      = 4'd7,
    REASON_AMBIENT   = 4'd8,
    REASON_OBJECT    = 4'd9
  } reason_t;

  localparam logic [21:0] HEARTBEAT_RESET = 22'd30000;
  localparam logic [10:0] PAN_DB_RESET    = 11'd15;
  localparam logic [7:0]  TILT_DB_RESET   = 8'd5;
  localparam logic [9:0]  AMB_DB_RESET    = 10'd5;
  localparam logic [9:0]  OBJ_DB_RESET    = 10'd10;

  // sentinel of an empty cache, far outside any real reading
  localparam logic signed [15:0] PREV_PAN_RESET  = -16'sd9990;
  localparam logic signed [10:0] PREV_TILT_RESET = -11'sd999;
  localparam logic signed [15:0] PREV_TEMP_RESET = -16'sd9990;

  typedef struct packed {
    logic [21:0] heartbeat_ms;
    logic [10:0] pan_deadband;
    logic [7:0]  tilt_deadband;
    logic [9:0]  ambient_deadband;
    logic [9:0]  object_deadband;
  } cfg_t;

  typedef struct packed {
    logic               force_req;
    logic [31:0]        now_ms;
    logic [10:0]        pan_tenths;
    logic [7:0]         tilt_deg;
    logic [FLAG_W-1:0]  fire_flags;
    logic               tilt_fire;
    logic               pump_on;
    logic signed [11:0] ambient_tenths;
    logic               ambient_ok;
    logic signed [12:0] object_tenths;
    logic               object_ok;
    logic               sent_ok;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pan;
    logic signed [10:0] tilt;
    logic [FLAG_W-1:0]  flags;
    logic               tilt_fire;
    logic               pump;
    logic signed [15:0] ambient;
    logic               ambient_ok;
    logic signed [15:0] object;
    logic               object_ok;
    logic [31:0]        last_report_ms;
  } cache_t;

  typedef struct packed {
    logic [10:0]        out_pan;
    logic [7:0]         out_tilt;
    logic [FLAG_W-1:0]  out_flags;
    logic               out_tilt_fire;
    logic               out_pump;
    logic signed [11:0] out_ambient;
    logic signed [12:0] out_object;
  } report_t;

endpackage

### rtl/drf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_cfg_regs
// Threshold and heartbeat registers behind the plain write port.
// ----------------------------------------------------------------------------
module drf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [drf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [drf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output drf_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_ms     <= drf_pkg::HEARTBEAT_RESET;
      cfg.pan_deadband     <= drf_pkg::PAN_DB_RESET;
      cfg.tilt_deadband    <= drf_pkg::TILT_DB_RESET;
      cfg.ambient_deadband <= drf_pkg::AMB_DB_RESET;
      cfg.object_deadband  <= drf_pkg::OBJ_DB_RESET;
    end else if (cfg_wr_en) begin
      case (drf_pkg::cfg_reg_t'(cfg_index))
        drf_pkg::CFG_HEARTBEAT: cfg.heartbeat_ms     <= cfg_data[21:0];
        drf_pkg::CFG_PAN_DB:    cfg.pan_deadband     <= cfg_data[10:0];
        drf_pkg::CFG_TILT_DB:   cfg.tilt_deadband    <= cfg_data[7:0];
        drf_pkg::CFG_AMB_DB:    cfg.ambient_deadband <= cfg_data[9:0];
        drf_pkg::CFG_OBJ_DB:    cfg.object_deadband  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/drf_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_cache
// Last published snapshot and heartbeat time, rewritten on a sent report.
// ----------------------------------------------------------------------------
module drf_cache (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                commit,
  input  drf_pkg::item_t                      item,
  input  logic [drf_pkg::FLAG_W-1:0]          flags,
  output drf_pkg::cache_t                     cache
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cache.pan            <= drf_pkg::PREV_PAN_RESET;
      cache.tilt           <= drf_pkg::PREV_TILT_RESET;
      cache.flags          <= '0;
      cache.tilt_fire      <= 1'b0;
      cache.pump           <= 1'b0;
      cache.ambient        <= drf_pkg::PREV_TEMP_RESET;
      cache.ambient_ok     <= 1'b1;
      cache.object         <= drf_pkg::PREV_TEMP_RESET;
      cache.object_ok      <= 1'b1;
      cache.last_report_ms <= '0;
    end else if (commit) begin
      cache.pan            <= $signed({5'b0, item.pan_tenths});
      cache.tilt           <= $signed({3'b0, item.tilt_deg});
      cache.flags          <= flags;
      cache.tilt_fire      <= item.tilt_fire;
      cache.pump           <= item.pump_on;
      cache.ambient        <= 16'(item.ambient_tenths);
      cache.ambient_ok     <= item.ambient_ok;
      cache.object         <= 16'(item.object_tenths);
      cache.object_ok      <= item.object_ok;
      cache.last_report_ms <= item.now_ms;
    end
  end

endmodule

### rtl/drf_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_decide
// Priority compare of one snapshot against the cache, gives reason and payload.
// ----------------------------------------------------------------------------
module drf_decide #(
  parameter int SENSOR_COUNT = drf_pkg::SENSOR_COUNT
) (
  input  drf_pkg::item_t   item,
  input  drf_pkg::cache_t  cache,
  input  drf_pkg::cfg_t    cfg,
  output drf_pkg::reason_t reason,
  output drf_pkg::report_t report
);

  function automatic logic [16:0] abs17(input logic signed [16:0] d);
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  logic [drf_pkg::FLAG_W-1:0] flag_mask;
  logic [drf_pkg::FLAG_W-1:0] flags;
  logic [31:0]                elapsed;
  logic signed [16:0]         pan_diff;
  logic signed [11:0]         tilt_diff;
  logic signed [16:0]         amb_diff;
  logic signed [16:0]         obj_diff;
  logic [16:0]                pan_abs;
  logic [11:0]                tilt_abs;
  logic [16:0]                amb_abs;
  logic [16:0]                obj_abs;

  always_comb begin
    for (int i = 0; i < drf_pkg::FLAG_W; i++) begin
      flag_mask[i] = (i < SENSOR_COUNT);
    end
  end

  assign flags   = item.fire_flags & flag_mask;
  assign elapsed = item.now_ms - cache.last_report_ms;

  assign pan_diff  = $signed({6'b0, item.pan_tenths}) - 17'(cache.pan);
  assign tilt_diff = $signed({4'b0, item.tilt_deg}) - 12'(cache.tilt);
  assign amb_diff  = 17'(item.ambient_tenths) - 17'(cache.ambient);
  assign obj_diff  = 17'(item.object_tenths) - 17'(cache.object);

  assign pan_abs  = abs17(pan_diff);
  assign tilt_abs = tilt_diff[11] ? 12'(-tilt_diff) : 12'(tilt_diff);
  assign amb_abs  = abs17(amb_diff);
  assign obj_abs  = abs17(obj_diff);

  always_comb begin
    if (item.force_req) begin
      reason = drf_pkg::REASON_FORCE;
    end else if (elapsed >= {10'b0, cfg.heartbeat_ms}) begin
      reason = drf_pkg::REASON_HEARTBEAT;
    end else if (item.pump_on != cache.pump) begin
      reason = drf_pkg::REASON_PUMP;
    end else if (item.tilt_fire != cache.tilt_fire) begin
      reason = drf_pkg::REASON_TILT_FIRE;
    end else if (flags != cache.flags) begin
      reason = drf_pkg::REASON_FLAGS;
    end else if (pan_abs > {6'b0, cfg.pan_deadband}) begin
      reason = drf_pkg::REASON_PAN;
    end else if (tilt_abs >= {4'b0, cfg.tilt_deadband}) begin
      reason = drf_pkg::REASON_TILT;
    end else if (item.ambient_ok && cache.ambient_ok &&
                 amb_abs > {7'b0, cfg.ambient_deadband}) begin
      reason = drf_pkg::REASON_AMBIENT;
    end else if (item.object_ok && cache.object_ok &&
                 obj_abs > {7'b0, cfg.object_deadband}) begin
      reason = drf_pkg::REASON_OBJECT;
    end else begin
      reason = drf_pkg::REASON_NONE;
    end
  end

  // no report means an all-zero payload
  always_comb begin
    report = '0;
    if (reason != drf_pkg::REASON_NONE) begin
      report.out_pan       = item.pan_tenths;
      report.out_tilt      = item.tilt_deg;
      report.out_flags     = flags;
      report.out_tilt_fire = item.tilt_fire;
      report.out_pump      = item.pump_on;
      report.out_ambient   = item.ambient_ok ? item.ambient_tenths : '0;
      report.out_object    = item.object_ok ? item.object_tenths : '0;
    end
  end

endmodule

### rtl/deadband_report_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_report_filter_core
// Report-by-exception filter with heartbeat for turret status snapshots.
// ----------------------------------------------------------------------------
// One snapshot beat is taken per clock while the output is not stalled, and
// one result beat comes out per snapshot: the beat lands in an input register,
// the priority compare against the cached copy runs in one combinational pass,
// and reason and payload land in the result register. The cache and the
// heartbeat time are written at the same edge as the result, so the next
// snapshot is already compared against them; this loop through the cache lets
// one beat per clock through. A stalled output holds the input register, and
// s_tready drops only when both registers are full. Reset restores the cache
// and the thresholds in the same cycle.
// ----------------------------------------------------------------------------
module deadband_report_filter_core #(
  parameter int SENSOR_COUNT = drf_pkg::SENSOR_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // force_req, now_ms, pan_tenths, tilt_deg, fire_flags, tilt_fire, pump_on,
  // ambient_tenths, ambient_ok, object_tenths, object_ok, sent_ok, zero pad
  input  logic [drf_pkg::IN_DATA_W-1:0]        s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // out_pan, out_tilt, out_flags, out_tilt_fire, out_pump, out_ambient,
  // out_object, zero pad
  output logic [drf_pkg::OUT_DATA_W-1:0]       m_tdata,
  // reason
  output logic [drf_pkg::OUT_USER_W-1:0]       m_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_wr_en,
  input  logic [drf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [drf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  drf_pkg::cfg_t    cfg;
  drf_pkg::cache_t  cache;
  drf_pkg::item_t   in_item;
  drf_pkg::item_t   s1_item;
  drf_pkg::reason_t reason;
  drf_pkg::report_t report;
  logic             s1_valid;
  logic             s1_adv;
  logic             commit;

  always_comb begin
    in_item.force_req      = s_tdata[0];
    in_item.now_ms         = s_tdata[32:1];
    in_item.pan_tenths     = s_tdata[43:33];
    in_item.tilt_deg       = s_tdata[51:44];
    in_item.fire_flags     = s_tdata[58:52];
    in_item.tilt_fire      = s_tdata[59];
    in_item.pump_on        = s_tdata[60];
    in_item.ambient_tenths = s_tdata[72:61];
    in_item.ambient_ok     = s_tdata[73];
    in_item.object_tenths  = s_tdata[86:74];
    in_item.object_ok      = s_tdata[87];
    in_item.sent_ok        = s_tdata[88];
  end

  // the snapshot moves on when the result register is free or being drained
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign commit   = s1_adv && (reason != drf_pkg::REASON_NONE) && s1_item.sent_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tuser <= reason;
      m_tdata <= {3'b0, report.out_object, report.out_ambient, report.out_pump,
                  report.out_tilt_fire, report.out_flags, report.out_tilt,
                  report.out_pan};
    end
  end

  drf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  drf_cache u_cache (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (s1_item),
    .flags  (report.out_flags),
    .cache  (cache)
  );

  drf_decide #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_decide (
    .item   (s1_item),
    .cache  (cache),
    .cfg    (cfg),
    .reason (reason),
    .report (report)
  );

`ifndef SYNTHESIS
  a_none_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == drf_pkg::REASON_NONE) |-> (m_tdata == '0))
    else $error("no-report beat carries a payload");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> s1_valid)
    else $error("snapshot lost while output stalled");

  a_cache_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(cache))
    else $error("cache changed without a sent report");

  a_not_ready_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid))
    else $error("input stalled with room in the pipe");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadband report filter: every snapshot beat is
// run through a cycle-free predictor of the priority compare and the
// published-copy cache, and every result beat is matched in order against it
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_WAIT     = 18;
  localparam logic [drf_pkg::FLAG_W-1:0] SENSOR_MASK =
    (drf_pkg::SENSOR_COUNT >= drf_pkg::FLAG_W) ? '1 :
    drf_pkg::FLAG_W'((1 << drf_pkg::SENSOR_COUNT) - 1);

  typedef struct packed {
    drf_pkg::reason_t reason;
    drf_pkg::report_t rpt;
  } filter_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [drf_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [drf_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic [drf_pkg::OUT_USER_W-1:0]  m_tuser;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [drf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [drf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the thresholds and of the published snapshot
  drf_pkg::cfg_t   cfg_model;
  drf_pkg::cache_t pub;

  filter_result_t expected_reports[$];
  int             fail_count = 0;
  int             rx_wait = 0;
  int             stall_cycles = 0;
  bit             tx_busy = 1'b1;
  bit             rx_busy = 1'b1;

  drf_pkg::item_t snap;
  drf_pkg::item_t walk;
  logic [31:0]    sim_now;

  deadband_report_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endfunction

  function automatic int draw_wait(bit busy);
    return busy ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  function automatic int abs_diff(int a, int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic string show_report(filter_result_t r);
    return $sformatf("reason %0d pan %0d tilt %0d flags %h tfire %b pump %b amb %0d obj %0d",
                     r.reason, r.rpt.out_pan, r.rpt.out_tilt, r.rpt.out_flags,
                     r.rpt.out_tilt_fire, r.rpt.out_pump, r.rpt.out_ambient,
                     r.rpt.out_object);
  endfunction

  function automatic void model_reset();
    cfg_model.heartbeat_ms     = drf_pkg::HEARTBEAT_RESET;
    cfg_model.pan_deadband     = drf_pkg::PAN_DB_RESET;
    cfg_model.tilt_deadband    = drf_pkg::TILT_DB_RESET;
    cfg_model.ambient_deadband = drf_pkg::AMB_DB_RESET;
    cfg_model.object_deadband  = drf_pkg::OBJ_DB_RESET;
    pub.pan            = drf_pkg::PREV_PAN_RESET;
    pub.tilt           = drf_pkg::PREV_TILT_RESET;
    pub.flags          = '0;
    pub.tilt_fire      = 1'b0;
    pub.pump           = 1'b0;
    pub.ambient        = drf_pkg::PREV_TEMP_RESET;
    pub.ambient_ok     = 1'b1;
    pub.object         = drf_pkg::PREV_TEMP_RESET;
    pub.object_ok      = 1'b1;
    pub.last_report_ms = '0;
  endfunction

  // priority compare against the published copy; the copy moves only on a
  // report that went out
  function automatic filter_result_t predict_report(drf_pkg::item_t it);
    filter_result_t             res;
    logic [drf_pkg::FLAG_W-1:0] flags;
    logic [31:0]                elapsed;
    int                         pan, tilt, amb, obj;
    res     = '0;
    flags   = it.fire_flags & SENSOR_MASK;
    elapsed = it.now_ms - pub.last_report_ms;
    pan     = int'(it.pan_tenths);
    tilt    = int'(it.tilt_deg);
    amb     = int'($signed(it.ambient_tenths));
    obj     = int'($signed(it.object_tenths));
    if (it.force_req) begin
      res.reason = drf_pkg::REASON_FORCE;
    end else if (elapsed >= 32'(cfg_model.heartbeat_ms)) begin
      res.reason = drf_pkg::REASON_HEARTBEAT;
    end else if (it.pump_on != pub.pump) begin
      res.reason = drf_pkg::REASON_PUMP;
    end else if (it.tilt_fire != pub.tilt_fire) begin
      res.reason = drf_pkg::REASON_TILT_FIRE;
    end else if (flags != pub.flags) begin
      res.reason = drf_pkg::REASON_FLAGS;
    end else if (abs_diff(pan, int'($signed(pub.pan))) >
                 int'(cfg_model.pan_deadband)) begin
      res.reason = drf_pkg::REASON_PAN;
    end else if (abs_diff(tilt, int'($signed(pub.tilt))) >=
                 int'(cfg_model.tilt_deadband)) begin
      res.reason = drf_pkg::REASON_TILT;
    end else if (it.ambient_ok && pub.ambient_ok &&
                 abs_diff(amb, int'($signed(pub.ambient))) >
                 int'(cfg_model.ambient_deadband)) begin
      res.reason = drf_pkg::REASON_AMBIENT;
    end else if (it.object_ok && pub.object_ok &&
                 abs_diff(obj, int'($signed(pub.object))) >
                 int'(cfg_model.object_deadband)) begin
      res.reason = drf_pkg::REASON_OBJECT;
    end else begin
      res.reason = drf_pkg::REASON_NONE;
    end
    if (res.reason != drf_pkg::REASON_NONE) begin
      res.rpt.out_pan       = it.pan_tenths;
      res.rpt.out_tilt      = it.tilt_deg;
      res.rpt.out_flags     = flags;
      res.rpt.out_tilt_fire = it.tilt_fire;
      res.rpt.out_pump      = it.pump_on;
      res.rpt.out_ambient   = it.ambient_ok ? it.ambient_tenths : '0;
      res.rpt.out_object    = it.object_ok ? it.object_tenths : '0;
      if (it.sent_ok) begin
        pub.last_report_ms = it.now_ms;
        pub.pan            = {5'd0, it.pan_tenths};
        pub.tilt           = {3'd0, it.tilt_deg};
        pub.flags          = flags;
        pub.tilt_fire      = it.tilt_fire;
        pub.pump           = it.pump_on;
        pub.ambient        = {{4{it.ambient_tenths[11]}}, it.ambient_tenths};
        pub.ambient_ok     = it.ambient_ok;
        pub.object         = {{3{it.object_tenths[12]}}, it.object_tenths};
        pub.object_ok      = it.object_ok;
      end
    end
    return res;
  endfunction

  task automatic send_snapshot(input drf_pkg::item_t it);
    int gap;
    gap = draw_wait(tx_busy);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.sent_ok, it.object_ok, it.object_tenths, it.ambient_ok,
                 it.ambient_tenths, it.pump_on, it.tilt_fire, it.fire_flags,
                 it.tilt_deg, it.pan_tenths, it.now_ms, it.force_req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_reports.push_back(predict_report(it));
  endtask

  // stop sending and let every outstanding report come back
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [drf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [drf_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      drf_pkg::CFG_HEARTBEAT: cfg_model.heartbeat_ms     = value;
      drf_pkg::CFG_PAN_DB:    cfg_model.pan_deadband     = value[10:0];
      drf_pkg::CFG_TILT_DB:   cfg_model.tilt_deadband    = value[7:0];
      drf_pkg::CFG_AMB_DB:    cfg_model.ambient_deadband = value[9:0];
      drf_pkg::CFG_OBJ_DB:    cfg_model.object_deadband  = value[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [drf_pkg::CFG_DATA_W-1:0] hb, pan_db,
                                  tilt_db, amb_db, obj_db);
    settle_idle();
    write_reg(drf_pkg::CFG_HEARTBEAT, hb);
    write_reg(drf_pkg::CFG_PAN_DB, pan_db);
    write_reg(drf_pkg::CFG_TILT_DB, tilt_db);
    write_reg(drf_pkg::CFG_AMB_DB, amb_db);
    write_reg(drf_pkg::CFG_OBJ_DB, obj_db);
  endtask

  // mostly a slow random walk from the last walked snapshot so the deadbands
  // matter; now and then a snapshot of pure noise
  function automatic drf_pkg::item_t next_random_snapshot();
    drf_pkg::item_t it;
    if ($urandom_range(0, 15) == 0) begin
      it.force_req      = 1'($urandom);
      it.now_ms         = $urandom;
      it.pan_tenths     = 11'($urandom);
      it.tilt_deg       = 8'($urandom);
      it.fire_flags     = 7'($urandom);
      it.tilt_fire      = 1'($urandom);
      it.pump_on        = 1'($urandom);
      it.ambient_tenths = 12'($urandom);
      it.ambient_ok     = 1'($urandom);
      it.object_tenths  = 13'($urandom);
      it.object_ok      = 1'($urandom);
      it.sent_ok        = 1'($urandom);
      return it;
    end
    sim_now += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
                                           : $urandom_range(0, 1500);
    walk.now_ms     = sim_now;
    walk.force_req  = ($urandom_range(0, 23) == 0);
    walk.sent_ok    = ($urandom_range(0, 3) != 0);
    walk.pan_tenths = 11'(clamp(int'(walk.pan_tenths) + int'($urandom_range(0, 40)) - 20,
                                0, 1800));
    walk.tilt_deg   = 8'(clamp(int'(walk.tilt_deg) + int'($urandom_range(0, 12)) - 6,
                               0, 150));
    walk.ambient_tenths = 12'(clamp(int'($signed(walk.ambient_tenths)) +
                                    int'($urandom_range(0, 16)) - 8, -400, 1250));
    walk.object_tenths  = 13'(clamp(int'($signed(walk.object_tenths)) +
                                    int'($urandom_range(0, 30)) - 15, -700, 3800));
    if ($urandom_range(0, 15) == 0) walk.pump_on = ~walk.pump_on;
    if ($urandom_range(0, 15) == 0) walk.tilt_fire = ~walk.tilt_fire;
    if ($urandom_range(0, 11) == 0) begin
      walk.fire_flags[$urandom_range(0, drf_pkg::FLAG_W - 1)] ^= 1'b1;
    end
    walk.ambient_ok = ($urandom_range(0, 9) != 0);
    walk.object_ok  = ($urandom_range(0, 9) != 0);
    return walk;
  endfunction

  task automatic run_random_phase(input int count,
                                  input logic [drf_pkg::CFG_DATA_W-1:0] hb, pan_db,
                                  tilt_db, amb_db, obj_db);
    write_thresholds(hb, pan_db, tilt_db, amb_db, obj_db);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_busy = ($urandom_range(0, 3) != 0);
        rx_busy = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 59) == 0) settle_idle();
      send_snapshot(next_random_snapshot());
    end
  endtask

  // first snapshots after reset meet the empty-cache sentinels; an unsent
  // report must leave the cache alone
  task automatic test_publish_gate();
    snap = '0;
    snap.now_ms         = 32'd100;
    snap.pan_tenths     = 11'd900;
    snap.tilt_deg       = 8'd75;
    snap.ambient_tenths = 12'sd250;
    snap.ambient_ok     = 1'b1;
    snap.object_tenths  = 13'sd300;
    snap.object_ok      = 1'b1;
    snap.sent_ok        = 1'b0;
    send_snapshot(snap);
    snap.sent_ok = 1'b1;
    send_snapshot(snap);
    send_snapshot(snap);
  endtask

  task automatic test_reason_priority();
    snap.force_req = 1'b1;
    snap.sent_ok   = 1'b0;
    send_snapshot(snap);
    snap.force_req = 1'b0;
    snap.sent_ok   = 1'b1;
    snap.now_ms    = snap.now_ms + 32'(drf_pkg::HEARTBEAT_RESET);
    send_snapshot(snap);
    snap.now_ms  = snap.now_ms + 32'd10;
    snap.pump_on = 1'b1;
    send_snapshot(snap);
    snap.tilt_fire = 1'b1;
    send_snapshot(snap);
    snap.fire_flags = 7'h55;
    send_snapshot(snap);
    // pan exactly on the deadband stays quiet, one more tenth reports
    snap.pan_tenths = snap.pan_tenths + 11'(drf_pkg::PAN_DB_RESET);
    send_snapshot(snap);
    snap.pan_tenths = snap.pan_tenths + 11'd1;
    send_snapshot(snap);
    snap.tilt_deg = snap.tilt_deg + drf_pkg::TILT_DB_RESET;
    send_snapshot(snap);
    snap.ambient_tenths = snap.ambient_tenths + 12'sd6;
    send_snapshot(snap);
    snap.object_tenths = snap.object_tenths + 13'sd11;
    send_snapshot(snap);
    // invalid temperature skips its compare, both current and published side
    snap.ambient_ok     = 1'b0;
    snap.ambient_tenths = snap.ambient_tenths - 12'sd500;
    send_snapshot(snap);
    snap.pan_tenths = snap.pan_tenths + 11'd20;
    send_snapshot(snap);
    snap.ambient_ok = 1'b1;
    send_snapshot(snap);
  endtask

  task automatic test_timer_wrap();
    snap.force_req = 1'b1;
    snap.now_ms    = 32'hFFFF_FF00;
    send_snapshot(snap);
    snap.force_req = 1'b0;
    snap.now_ms    = 32'h0000_7000;
    send_snapshot(snap);
    snap.now_ms = 32'(drf_pkg::HEARTBEAT_RESET) - 32'h100;
    send_snapshot(snap);
  endtask

  task automatic test_field_extremes();
    snap.force_req      = 1'b1;
    snap.now_ms         = 32'hFFFF_FFFF;
    snap.pan_tenths     = '1;
    snap.tilt_deg       = '1;
    snap.fire_flags     = '1;
    snap.ambient_tenths = 12'h800;
    snap.object_tenths  = 13'h1000;
    send_snapshot(snap);
    snap.force_req      = 1'b0;
    snap.pan_tenths     = '0;
    snap.tilt_deg       = '0;
    snap.ambient_tenths = 12'h7FF;
    snap.object_tenths  = 13'h0FFF;
    send_snapshot(snap);
  endtask

  task automatic test_config_space();
    // zero heartbeat turns every snapshot without force_req into a heartbeat report
    write_thresholds('0, drf_pkg::PAN_DB_RESET, drf_pkg::TILT_DB_RESET,
                     drf_pkg::AMB_DB_RESET, drf_pkg::OBJ_DB_RESET);
    send_snapshot(snap);
    send_snapshot(snap);
    settle_idle();
    for (int i = int'(drf_pkg::CFG_OBJ_DB) + 1; i < (1 << drf_pkg::CFG_INDEX_W); i++) begin
      write_reg(drf_pkg::CFG_INDEX_W'(i), '1);
    end
    send_snapshot(snap);
    // all-ones data, each register keeps only its own width
    write_thresholds('1, '1, '1, '1, '1);
    snap.now_ms        = snap.now_ms + 32'd5;
    snap.pan_tenths    = snap.pan_tenths + 11'd600;
    snap.object_tenths = snap.object_tenths - 13'sd900;
    send_snapshot(snap);
    snap.tilt_deg = snap.tilt_deg + 8'd200;
    send_snapshot(snap);
  endtask

  task automatic test_random_traffic();
    walk    = snap;
    sim_now = 32'hFFFE_0000;
    run_random_phase(200, drf_pkg::HEARTBEAT_RESET, drf_pkg::PAN_DB_RESET,
                     drf_pkg::TILT_DB_RESET, drf_pkg::AMB_DB_RESET,
                     drf_pkg::OBJ_DB_RESET);
    run_random_phase(200, 22'd1, '0, '0, '0, '0);
    run_random_phase(200, 22'd3600000, 22'd1800, 22'd150, 22'd1000, 22'd1000);
    run_random_phase(200, 22'($urandom_range(1, 60000)), 22'($urandom_range(0, 2047)),
                     22'($urandom_range(0, 255)), 22'($urandom_range(0, 1023)),
                     22'($urandom_range(0, 1023)));
  endtask

  // result side: random stall after each beat, in-order check
  always @(posedge clk) begin
    filter_result_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.reason            = drf_pkg::reason_t'(m_tuser);
        got.rpt.out_pan       = m_tdata[10:0];
        got.rpt.out_tilt      = m_tdata[18:11];
        got.rpt.out_flags     = m_tdata[25:19];
        got.rpt.out_tilt_fire = m_tdata[26];
        got.rpt.out_pump      = m_tdata[27];
        got.rpt.out_ambient   = m_tdata[39:28];
        got.rpt.out_object    = m_tdata[52:40];
        if (expected_reports.size() == 0) begin
          note_failure($sformatf("unexpected result beat: %s", show_report(got)));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            note_failure($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
                                   $realtime, show_report(want), show_report(got)));
          end
        end
        rx_wait = draw_wait(rx_busy);
        m_tready <= (rx_wait == 0);
      end else if (!m_tready) begin
        if (rx_wait > 0) rx_wait--;
        m_tready <= (rx_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_publish_gate();
    test_reason_priority();
    test_timer_wrap();
    test_field_extremes();
    test_config_space();
    test_random_traffic();
    settle_idle();
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
